[hw/rtl/cme_pkg.sv]
// Shared types and constants for the common modulus enumerator.
package cme_pkg;

  localparam logic [1:0] MODE_FIRST   = 2'd0;
  localparam logic [1:0] MODE_FURTHER = 2'd1;
  localparam logic [1:0] MODE_FETCH   = 2'd2;
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  typedef enum logic [1:0] {
    PH_SMALL = 2'd0,
    PH_LARGE = 2'd1,
    PH_DONE  = 2'd2
  } phase_t;

endpackage

[hw/rtl/cme_divider.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
module cme_divider #(
  parameter int W = 30
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0] quo_r, quo_nxt;
  logic [W-1:0] rem_r, rem_nxt;
  logic [W-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [W:0] trial;

  assign trial = {rem_r, quo_r[W-1]};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in next dividend bit, subtract if it fits
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[hw/rtl/common_modulus_enumerator_unit.sv]
// Top level of the common modulus enumerator.
//
// Input channel (in_valid/in_stall, in_mode, in_value): mode 0 starts a new
// set with its first number, mode 1 adds a number, mode 2 fetches the next
// modulus, mode 3 is ignored. Loads produce no result beat; each fetch
// produces exactly one beat on the output channel (out_modulus,
// out_exhausted). Moduli come out in ascending order; a beat with
// out_exhausted high and modulus 0 ends the list and repeats from then on.
// One item is worked at a time: in_stall is high while busy.
// A load of a further number runs Euclid on a shared bit-serial divider.
// A fetch tests trial divisors one at a time. Small half: each trial
// squares t bit-serially (t is TW bits wide, TW = (VALUE_BITS+1)/2+1) and
// then divides. Large half: each trial is one divide; its quotient is the
// cofactor. The count of trials to the next divisor sets the fetch latency;
// a fetch with nothing left puts its beat in the output register the cycle
// after acceptance. Reset (rst_n low, synchronous) clears the set: GCD 0,
// so fetches report exhaustion at once. While out_stall is high the result
// beat holds in the output register and no new input beat is taken.
module common_modulus_enumerator_unit #(
  parameter int VALUE_BITS = 30
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_mode,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] out_modulus,
  output logic                  out_exhausted
);
  import cme_pkg::*;

  localparam int W = VALUE_BITS;
  localparam int TW = (W + 1) / 2 + 1;  // trial divisor width
  localparam int MW = $clog2(TW + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EUC   = 6'b000010,  // euclid remainder in flight
    S_SQ    = 6'b000100,  // serial t*t compare
    S_TDIV  = 6'b001000,  // g % t in flight (small half)
    S_LDIV  = 6'b010000,  // g % t in flight (large half)
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [W-1:0]  first_r, first_nxt;
  logic [W-1:0]  gcd_r, gcd_nxt;
  logic [W-1:0]  eb_r, eb_nxt;      // euclid second operand
  logic [TW-1:0] trial_r, trial_nxt;
  phase_t        phase_r, phase_nxt;
  logic [W-1:0]  mod_r, mod_nxt;
  logic          exh_r, exh_nxt;
  // serial squarer: acc += t << i for each set bit i of t
  logic [2*TW-1:0] sq_acc_r, sq_acc_nxt;
  logic [2*TW-1:0] sq_add_r, sq_add_nxt;
  logic [TW-1:0]   sq_bits_r, sq_bits_nxt;
  logic [MW-1:0]   sq_cnt_r, sq_cnt_nxt;

  logic         dv_start;
  logic [W-1:0] dv_a, dv_b;
  logic         dv_done;
  logic [W-1:0] dv_q, dv_r;

  cme_divider #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a),
    .divisor(dv_b), .done(dv_done), .quotient(dv_q), .remainder(dv_r)
  );

  logic [W-1:0]  diff;
  logic [W-1:0]  trial_w;
  logic          accept;

  assign accept  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign trial_w = W'(trial_r);
  assign diff = (in_value >= first_r) ? in_value - first_r : first_r - in_value;

  always_comb begin
    state_nxt   = state_r;
    first_nxt   = first_r;
    gcd_nxt     = gcd_r;
    eb_nxt      = eb_r;
    trial_nxt   = trial_r;
    phase_nxt   = phase_r;
    mod_nxt     = mod_r;
    exh_nxt     = exh_r;
    sq_acc_nxt  = sq_acc_r;
    sq_add_nxt  = sq_add_r;
    sq_bits_nxt = sq_bits_r;
    sq_cnt_nxt  = sq_cnt_r;
    dv_start    = 1'b0;
    dv_a        = gcd_r;
    dv_b        = trial_w;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_FIRST) begin
            first_nxt = in_value;
            gcd_nxt   = '0;
            trial_nxt = TW'(2);
            phase_nxt = PH_SMALL;
          end else if (in_mode == MODE_FURTHER) begin
            trial_nxt = TW'(2);
            phase_nxt = PH_SMALL;
            eb_nxt    = diff;
            if (diff != '0) begin
              // gcd(a,b): if a is 0 answer is b; start a % b
              if (gcd_r == '0) begin
                gcd_nxt = diff;
              end else begin
                dv_start  = 1'b1;
                dv_a      = gcd_r;
                dv_b      = diff;
                state_nxt = S_EUC;
              end
            end
          end else if (in_mode == MODE_FETCH) begin
            if (gcd_r < W'(2) || phase_r == PH_DONE) begin
              phase_nxt = PH_DONE;
              mod_nxt   = '0;
              exh_nxt   = 1'b1;
              state_nxt = S_OUT;
            end else if (phase_r == PH_SMALL) begin
              sq_acc_nxt  = '0;
              sq_add_nxt  = (2*TW)'(trial_r);
              sq_bits_nxt = trial_r;
              sq_cnt_nxt  = MW'(TW);
              state_nxt   = S_SQ;
            end else begin
              dv_start  = 1'b1;
              state_nxt = S_LDIV;
            end
          end
        end
      end
      S_EUC: begin
        if (dv_done) begin
          if (dv_r == '0) begin
            gcd_nxt   = eb_r;
            state_nxt = S_IDLE;
          end else begin
            gcd_nxt  = eb_r;
            eb_nxt   = dv_r;
            dv_start = 1'b1;
            dv_a     = eb_r;
            dv_b     = dv_r;
          end
        end
      end
      S_SQ: begin
        if (sq_bits_r[0]) sq_acc_nxt = sq_acc_r + sq_add_r;
        sq_add_nxt  = sq_add_r << 1;
        sq_bits_nxt = sq_bits_r >> 1;
        sq_cnt_nxt  = sq_cnt_r - 1'b1;
        if (sq_cnt_r == MW'(1)) begin
          if ((sq_bits_r[0] ? sq_acc_r + sq_add_r : sq_acc_r) <= (2*TW)'(gcd_r)) begin
            dv_start  = 1'b1;
            state_nxt = S_TDIV;
          end else begin
            // switch to large half at t-1
            phase_nxt = PH_LARGE;
            trial_nxt = trial_r - 1'b1;
            dv_start  = 1'b1;
            dv_b      = W'(trial_r - 1'b1);
            state_nxt = S_LDIV;
          end
        end
      end
      S_TDIV: begin
        if (dv_done) begin
          if (dv_r == '0) begin
            mod_nxt   = trial_w;
            exh_nxt   = 1'b0;
            trial_nxt = trial_r + 1'b1;
            state_nxt = S_OUT;
          end else begin
            trial_nxt   = trial_r + 1'b1;
            sq_acc_nxt  = '0;
            sq_add_nxt  = (2*TW)'(trial_r + 1'b1);
            sq_bits_nxt = trial_r + 1'b1;
            sq_cnt_nxt  = MW'(TW);
            state_nxt   = S_SQ;
          end
        end
      end
      S_LDIV: begin
        if (dv_done) begin
          if (trial_r == '0) begin
            phase_nxt = PH_DONE;
            mod_nxt   = '0;
            exh_nxt   = 1'b1;
            state_nxt = S_OUT;
          end else if (dv_r == '0 && dv_q != trial_w) begin
            // cofactor already in quotient
            mod_nxt   = dv_q;
            exh_nxt   = 1'b0;
            if (trial_r == TW'(1)) phase_nxt = PH_DONE;
            trial_nxt = trial_r - 1'b1;
            state_nxt = S_OUT;
          end else begin
            trial_nxt = trial_r - 1'b1;
            dv_start  = 1'b1;
            dv_b      = W'(trial_r - 1'b1);
          end
        end
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      first_r <= '0;
      gcd_r   <= '0;
      trial_r <= TW'(2);
      phase_r <= PH_SMALL;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
      gcd_r   <= gcd_nxt;
      trial_r <= trial_nxt;
      phase_r <= phase_nxt;
    end
    eb_r      <= eb_nxt;
    mod_r     <= mod_nxt;
    exh_r     <= exh_nxt;
    sq_acc_r  <= sq_acc_nxt;
    sq_add_r  <= sq_add_nxt;
    sq_bits_r <= sq_bits_nxt;
    sq_cnt_r  <= sq_cnt_nxt;
  end

  assign out_valid     = (state_r == S_OUT);
  assign out_modulus   = mod_r;
  assign out_exhausted = exh_r;

endmodule

[verif/tb_common_modulus_enumerator_unit.sv]
// Self-checking testbench for common_modulus_enumerator_unit.
`timescale 1ns / 1ps

module tb_common_modulus_enumerator_unit;
  import cme_pkg::*;

  typedef struct {
    logic [29:0] modulus;
    logic        exhausted;
  } modulus_beat_t;

  // Keeps its own copy of the set state and the expected result beats.
  class modulus_scoreboard;
    longint unsigned first_value;
    longint unsigned common_gcd;
    longint unsigned trial_div;
    phase_t          phase;
    modulus_beat_t   expected_moduli[$];
    int              errors;
    int              fetches_seen;
    int              exhaust_seen;

    function new();
      first_value = 0;
      common_gcd  = 0;
      trial_div   = 2;
      phase       = PH_SMALL;
      errors      = 0;
      fetches_seen = 0;
      exhaust_seen = 0;
    endfunction

    function longint unsigned euclid(longint unsigned a, longint unsigned b);
      longint unsigned r;
      while (b != 0) begin
        r = a % b;
        a = b;
        b = r;
      end
      return a;
    endfunction

    // Next divisor above 1 of the gcd, ascending; zero with exhausted when none left.
    function modulus_beat_t next_modulus();
      modulus_beat_t   beat;
      longint unsigned g;
      longint unsigned t;
      longint unsigned q;
      g = common_gcd;
      beat.modulus   = '0;
      beat.exhausted = 1'b1;
      if (g < 2) phase = PH_DONE;
      if (phase == PH_SMALL) begin
        t = trial_div;
        while (t * t <= g) begin
          if (g % t == 0) begin
            trial_div = t + 1;
            beat.modulus   = t[29:0];
            beat.exhausted = 1'b0;
            return beat;
          end
          t++;
        end
        phase     = PH_LARGE;
        trial_div = t - 1;
      end
      if (phase == PH_LARGE) begin
        t = trial_div;
        while (t >= 1) begin
          if (g % t == 0 && t * t != g) begin
            if (t == 1) phase = PH_DONE;
            trial_div = t - 1;
            q = g / t;
            beat.modulus   = q[29:0];
            beat.exhausted = 1'b0;
            return beat;
          end
          t--;
        end
        phase = PH_DONE;
      end
      return beat;
    endfunction

    function void note_beat(logic [1:0] mode, logic [29:0] value);
      longint unsigned v;
      v = 64'(value);
      case (mode)
        MODE_FIRST: begin
          first_value = v;
          common_gcd  = 0;
          trial_div   = 2;
          phase       = PH_SMALL;
        end
        MODE_FURTHER: begin
          common_gcd = euclid(common_gcd,
                              (v >= first_value) ? v - first_value : first_value - v);
          trial_div  = 2;
          phase      = PH_SMALL;
        end
        MODE_FETCH: expected_moduli.insert(expected_moduli.size(), next_modulus());
        default: ;
      endcase
    endfunction

    function void check_beat(logic [29:0] modulus, logic exhausted);
      modulus_beat_t exp_beat;
      if (expected_moduli.size() == 0) begin
        $error("unexpected result beat: modulus %0d exhausted %0d", modulus, exhausted);
        errors++;
        return;
      end
      exp_beat = expected_moduli.pop_front();
      fetches_seen++;
      if (exp_beat.exhausted) exhaust_seen++;
      if (modulus !== exp_beat.modulus) begin
        $error("modulus: expected %0d, got %0d", exp_beat.modulus, modulus);
        errors++;
      end
      if (exhausted !== exp_beat.exhausted) begin
        $error("exhausted: expected %0d, got %0d", exp_beat.exhausted, exhausted);
        errors++;
      end
    endfunction

    function int pending();
      return expected_moduli.size();
    endfunction
  endclass

  localparam int VALUE_BITS = 30;
  localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS) - 1;
  // Cycles without any beat before giving up; the slowest fetch here is about
  // a hundred trials, plus output stalls.
  localparam int HANG_LIMIT = 400000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_mode;
  logic [VALUE_BITS-1:0] in_value;
  logic                  out_valid;
  logic                  out_stall;
  logic [VALUE_BITS-1:0] out_modulus;
  logic                  out_exhausted;

  modulus_scoreboard sb;
  int idle_pct;   // sender idle chance per cycle, percent
  int stall_pct;  // receiver stall chance per cycle, percent
  int items_sent;
  int sets_loaded;
  int quiet_cycles;

  common_modulus_enumerator_unit #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_modulus  (out_modulus),
    .out_exhausted(out_exhausted)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Beat monitor: values read here are the ones the block saw at this edge,
  // since all driving is nonblocking at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_beat(in_mode, in_value);
      if (out_valid && !out_stall) sb.check_beat(out_modulus, out_exhausted);
    end
  end

  // Random receiver back-pressure.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else        out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: counts cycles with no beat on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("watchdog: no beat in %0d cycles", HANG_LIMIT);
        $display("tb_common_modulus_enumerator_unit NOT OK");
        $finish;
      end
    end
  end

  // One input beat. Idle gaps drop valid first; a back-to-back beat keeps it
  // high so valid gets only one assignment per edge.
  task automatic send_beat(logic [1:0] mode, logic [VALUE_BITS-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_mode  <= 2'($urandom());
      in_value <= VALUE_BITS'($urandom());
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Hold off until every fetch has been answered.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // A set whose differences are multiples of base, then some fetches.
  task automatic random_set();
    longint unsigned first;
    longint unsigned base;
    longint unsigned k;
    longint unsigned v;
    int nfurther;
    int nfetch;
    first = {$urandom(), $urandom()} & VALUE_MAX;
    base  = 64'($urandom_range(600, 2));
    if ($urandom_range(9) == 0) base = 64'($urandom_range(1, 0));
    send_beat(MODE_FIRST, VALUE_BITS'(first));
    sets_loaded++;
    nfurther = int'($urandom_range(4, 1));
    for (int i = 0; i < nfurther; i++) begin
      k = 64'($urandom_range(16, 0));
      if (first + k * base <= VALUE_MAX && ($urandom_range(1) || first < k * base))
        v = first + k * base;
      else
        v = first - k * base;
      send_beat(MODE_FURTHER, VALUE_BITS'(v));
      // occasional noise: ignored mode, or a fetch mid-load
      if ($urandom_range(9) == 0) send_beat(MODE_IGNORED, VALUE_BITS'($urandom()));
      if ($urandom_range(9) == 0) send_beat(MODE_FETCH, VALUE_BITS'($urandom()));
    end
    nfetch = ($urandom_range(3) == 0) ? 40 : int'($urandom_range(12, 1));
    for (int i = 0; i < nfetch; i++) send_beat(MODE_FETCH, VALUE_BITS'($urandom()));
  endtask

  initial begin
    sb = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_mode   = MODE_FIRST;
    in_value  = '0;
    idle_pct  = 0;
    stall_pct = 0;
    items_sent  = 0;
    sets_loaded = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fetch before any load reports exhaustion at once.
    send_beat(MODE_FETCH, '0);
    send_beat(MODE_IGNORED, VALUE_BITS'(VALUE_MAX));
    // Single-number set: gcd zero.
    send_beat(MODE_FIRST, '0);
    send_beat(MODE_FETCH, '0);
    // Equal numbers keep gcd zero.
    send_beat(MODE_FURTHER, '0);
    send_beat(MODE_FETCH, VALUE_BITS'(VALUE_MAX));
    // Extremes of value: gcd 2^30-1, first few divisors only.
    send_beat(MODE_FURTHER, VALUE_BITS'(VALUE_MAX));
    repeat (3) send_beat(MODE_FETCH, '0);
    // gcd 1: exhausted right away.
    send_beat(MODE_FIRST, 30'd100);
    send_beat(MODE_FURTHER, 30'd101);
    send_beat(MODE_FETCH, '0);
    // Perfect square 36: root given once, last is 36, then exhausted twice.
    send_beat(MODE_FIRST, 30'd50);
    send_beat(MODE_FURTHER, 30'd14);
    repeat (10) send_beat(MODE_FETCH, '0);
    // Difference 13 joins gcd 36, giving gcd 1, restarted by a reload partway.
    send_beat(MODE_FURTHER, 30'd63);
    send_beat(MODE_FETCH, '0);
    send_beat(MODE_FURTHER, 30'd37);
    repeat (3) send_beat(MODE_FETCH, '0);
    drain();

    // Random part, stepped through the idle/stall mixes.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      while (items_sent < 25 + (ph + 1) * 100) begin
        random_set();
        if ($urandom_range(7) == 0) drain();
      end
    end

    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d input beats over %0d sets, %0d fetch results (%0d exhausted)",
             items_sent, sets_loaded, sb.fetches_seen, sb.exhaust_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_common_modulus_enumerator_unit OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
      $display("tb_common_modulus_enumerator_unit NOT OK");
    end
    $finish;
  end
endmodule
